// File: sv/mcg_pkg.sv
// shared types, constants and calendar tables for the month calendar grid navigator
// no dependencies; every other file refers to it by scoped names
package mcg_pkg;

  localparam int CENT_W      = 7;
  localparam int YEAR_W      = 7;
  localparam int MON_W       = 4;
  localparam int DAY_W       = 5;
  localparam int ROW_W       = 3;
  localparam int COL_W       = 5;
  localparam int CMD_W       = 3;
  localparam int CFG_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int SUM_W       = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_TODAY      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREV_MONTH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT_MONTH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PREV_YEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT_YEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_WEEKDAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MARGIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_GAP      = 2'd2;

  localparam logic [CENT_W-1:0] MAX_CY    = 7'd99;
  localparam logic [MON_W-1:0]  JANUARY   = 4'd1;
  localparam logic [MON_W-1:0]  FEBRUARY  = 4'd2;
  localparam logic [MON_W-1:0]  MARCH     = 4'd3;
  localparam logic [MON_W-1:0]  DECEMBER  = 4'd12;
  localparam logic [3:0]        DAYS_WEEK = 4'd7;
  localparam logic [1:0]        MAX_GAP   = 2'd2;

  typedef struct packed {
    logic [CENT_W-1:0] century;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } job_t;

  typedef struct packed {
    logic [2:0] first_weekday;
    logic [1:0] left_margin;
    logic [1:0] cell_gap;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_WDAY = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // month offset for the day-of-week sum
  function automatic logic [2:0] month_off(input logic [MON_W-1:0] m);
    logic [2:0] off;
    case (m)
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  // 8 is 1 mod 7, so octal digits fold down
  function automatic logic [2:0] mod7(input logic [SUM_W-1:0] s);
    logic [4:0] a;
    logic [3:0] b;
    a = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[9]);
    b = 4'(a[2:0]) + 4'(a[4:3]);
    if (b >= DAYS_WEEK) begin
      b = b - DAYS_WEEK;
    end
    return b[2:0];
  endfunction

endpackage

// File: sv/mcg_in_if.sv
// command channel: valid/ready handshake with the command word and current date
// uses mcg_pkg widths
interface mcg_in_if;
  logic                        valid;
  logic                        ready;
  logic [mcg_pkg::CMD_W-1:0]   command;
  logic [mcg_pkg::CENT_W-1:0]  now_century;
  logic [mcg_pkg::YEAR_W-1:0]  now_year;
  logic [mcg_pkg::MON_W-1:0]   now_month;
  logic [mcg_pkg::DAY_W-1:0]   now_day;

  modport source(output valid, command, now_century, now_year, now_month, now_day,
                 input ready);
  modport sink(input valid, command, now_century, now_year, now_month, now_day,
               output ready);
endinterface

// File: sv/mcg_out_if.sv
// cell channel: valid/ready handshake with one calendar cell word
// uses mcg_pkg widths
interface mcg_out_if;
  logic                        valid;
  logic                        ready;
  logic [mcg_pkg::DAY_W-1:0]   day_number;
  logic [mcg_pkg::ROW_W-1:0]   week_row;
  logic [mcg_pkg::COL_W-1:0]   char_column;
  logic                        highlight;
  logic [mcg_pkg::CENT_W-1:0]  shown_century_out;
  logic [mcg_pkg::YEAR_W-1:0]  shown_year_out;
  logic [mcg_pkg::MON_W-1:0]   shown_month_out;
  logic                        last_cell;

  modport source(output valid, day_number, week_row, char_column, highlight,
                 shown_century_out, shown_year_out, shown_month_out, last_cell,
                 input ready);
  modport sink(input valid, day_number, week_row, char_column, highlight,
               shown_century_out, shown_year_out, shown_month_out, last_cell,
               output ready);
endinterface

// File: sv/mcg_front.sv
// front end: takes command words, steps the shown month, queues a month job
// depends on mcg_pkg and mcg_in_if
module mcg_front (
  input  logic              clk,
  input  logic              rst_n,
  mcg_in_if.sink            in_ch,
  input  logic              q_ready,
  output logic              q_push,
  output mcg_pkg::job_t     q_job
);

  logic [mcg_pkg::CENT_W-1:0] shown_c_r, shown_c_nxt;
  logic [mcg_pkg::YEAR_W-1:0] shown_y_r, shown_y_nxt;
  logic [mcg_pkg::MON_W-1:0]  shown_m_r, shown_m_nxt;
  logic [mcg_pkg::DAY_W-1:0]  marked_r, marked_nxt;

  logic [mcg_pkg::CENT_W-1:0] nc, c_new;
  logic [mcg_pkg::YEAR_W-1:0] ny, y_new;
  logic [mcg_pkg::MON_W-1:0]  nm, m_new;
  logic [mcg_pkg::DAY_W-1:0]  d_new;
  logic                       same_now, same_after, emit, accept;

  always_comb begin
    nc = (in_ch.now_century > mcg_pkg::MAX_CY) ? mcg_pkg::MAX_CY : in_ch.now_century;
    ny = (in_ch.now_year > mcg_pkg::MAX_CY) ? mcg_pkg::MAX_CY : in_ch.now_year;
    if (in_ch.now_month < mcg_pkg::JANUARY) begin
      nm = mcg_pkg::JANUARY;
    end else if (in_ch.now_month > mcg_pkg::DECEMBER) begin
      nm = mcg_pkg::DECEMBER;
    end else begin
      nm = in_ch.now_month;
    end
    same_now = (shown_c_r == nc) && (shown_y_r == ny) && (shown_m_r == nm);

    c_new = shown_c_r;
    y_new = shown_y_r;
    m_new = shown_m_r;
    emit  = 1'b1;
    case (in_ch.command)
      mcg_pkg::CMD_TODAY: begin
        c_new = nc;
        y_new = ny;
        m_new = nm;
        // today already on screen with today marked
        if (same_now && (marked_r == in_ch.now_day)) begin
          emit = 1'b0;
        end
      end
      mcg_pkg::CMD_PREV_MONTH: begin
        if (shown_m_r > mcg_pkg::JANUARY) begin
          m_new = shown_m_r - 4'd1;
        end else if (shown_y_r != '0) begin
          m_new = mcg_pkg::DECEMBER;
          y_new = shown_y_r - 7'd1;
        end else if (shown_c_r != '0) begin
          m_new = mcg_pkg::DECEMBER;
          y_new = mcg_pkg::MAX_CY;
          c_new = shown_c_r - 7'd1;
        end
      end
      mcg_pkg::CMD_NEXT_MONTH: begin
        if (shown_m_r < mcg_pkg::DECEMBER) begin
          m_new = shown_m_r + 4'd1;
        end else if (shown_y_r < mcg_pkg::MAX_CY) begin
          m_new = mcg_pkg::JANUARY;
          y_new = shown_y_r + 7'd1;
        end else if (shown_c_r < mcg_pkg::MAX_CY) begin
          m_new = mcg_pkg::JANUARY;
          y_new = '0;
          c_new = shown_c_r + 7'd1;
        end
      end
      mcg_pkg::CMD_PREV_YEAR: begin
        if (shown_y_r != '0) begin
          y_new = shown_y_r - 7'd1;
        end else if (shown_c_r != '0) begin
          y_new = mcg_pkg::MAX_CY;
          c_new = shown_c_r - 7'd1;
        end
      end
      mcg_pkg::CMD_NEXT_YEAR: begin
        if (shown_y_r < mcg_pkg::MAX_CY) begin
          y_new = shown_y_r + 7'd1;
        end else if (shown_c_r < mcg_pkg::MAX_CY) begin
          y_new = '0;
          c_new = shown_c_r + 7'd1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    same_after = (c_new == nc) && (y_new == ny) && (m_new == nm);
    d_new      = same_after ? in_ch.now_day : '0;
  end

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign q_push      = accept && emit;
  assign q_job       = '{century: c_new, year: y_new, month: m_new, day: d_new};

  always_comb begin
    shown_c_nxt = q_push ? c_new : shown_c_r;
    shown_y_nxt = q_push ? y_new : shown_y_r;
    shown_m_nxt = q_push ? m_new : shown_m_r;
    marked_nxt  = q_push ? d_new : marked_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_c_r <= '0;
      shown_y_r <= '0;
      shown_m_r <= mcg_pkg::JANUARY;
      marked_r  <= '0;
    end else begin
      shown_c_r <= shown_c_nxt;
      shown_y_r <= shown_y_nxt;
      shown_m_r <= shown_m_nxt;
      marked_r  <= marked_nxt;
    end
  end

endmodule

// File: sv/mcg_queue.sv
// short job queue between the front end and the cell generator
// depends on mcg_pkg for the job type and depth
module mcg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mcg_pkg::job_t     push_job,
  output logic              push_ready,
  output logic              pop_valid,
  input  logic              pop,
  output mcg_pkg::job_t     pop_job
);

  mcg_pkg::job_t                slot_r [mcg_pkg::QUEUE_DEPTH];
  logic [mcg_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mcg_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mcg_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (cnt_r != mcg_pkg::QCNT_W'(mcg_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mcg_pkg::QPTR_W'(mcg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mcg_pkg::QPTR_W'(mcg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mcg_pkg::QCNT_W'(mcg_pkg::QUEUE_DEPTH))
    else $error("job queue count above depth");

  a_drop_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("job pushed into a full queue");

endmodule

// File: sv/mcg_back.sv
// cell generator: finds month length and first weekday, then emits one cell a cycle
// unless the output stalls; depends on mcg_pkg and mcg_out_if
module mcg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mcg_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  mcg_pkg::job_t     q_job,
  output logic              q_pop,
  mcg_out_if.source         out_ch
);

  mcg_pkg::back_state_t        state_r, state_nxt;
  mcg_pkg::job_t               job_r;
  logic [mcg_pkg::SUM_W-1:0]   s_r, s_nxt;
  logic [2:0]                  dw_r, dw_nxt;
  logic [mcg_pkg::DAY_W-1:0]   dm_r, dm_nxt;
  logic [mcg_pkg::DAY_W-1:0]   cd_r, cd_nxt;
  logic [mcg_pkg::ROW_W-1:0]   row_r, row_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [mcg_pkg::DAY_W-1:0]   day_r;
  logic [mcg_pkg::ROW_W-1:0]   orow_r;
  logic [mcg_pkg::COL_W-1:0]   col_r;
  logic                        hl_r, last_r;
  logic [mcg_pkg::CENT_W-1:0]  oc_r;
  logic [mcg_pkg::YEAR_W-1:0]  oy_r;
  logic [mcg_pkg::MON_W-1:0]   om_r;

  logic [mcg_pkg::CENT_W-1:0]  cp;
  logic [mcg_pkg::YEAR_W-1:0]  yp;
  logic [2:0]                  fdow;
  logic [3:0]                  shifted;
  logic                        leap, load, final_day;
  logic [1:0]                  gap;
  logic [2:0]                  step;
  logic [5:0]                  col_calc;

  // years from march, shifted by 400 so the sum stays positive
  always_comb begin
    if (job_r.month < mcg_pkg::MARCH) begin
      if (job_r.year != '0) begin
        yp = job_r.year - 7'd1;
        cp = job_r.century + 7'd4;
      end else begin
        yp = mcg_pkg::MAX_CY;
        cp = job_r.century + 7'd3;
      end
    end else begin
      yp = job_r.year;
      cp = job_r.century + 7'd4;
    end
    // 124 is 5 mod 7
    s_nxt = mcg_pkg::SUM_W'(cp) * 10'd5 + mcg_pkg::SUM_W'(yp) + mcg_pkg::SUM_W'(yp >> 2)
          + mcg_pkg::SUM_W'(cp >> 2) + mcg_pkg::SUM_W'(mcg_pkg::month_off(job_r.month))
          + 10'd1;
  end

  always_comb begin
    fdow    = mcg_pkg::mod7(s_r);
    shifted = 4'(fdow) + mcg_pkg::DAYS_WEEK - 4'(cfg.first_weekday);
    if (shifted >= mcg_pkg::DAYS_WEEK) begin
      shifted = shifted - mcg_pkg::DAYS_WEEK;
    end
    leap = (job_r.year[1:0] == 2'b00) &&
           ((job_r.year != '0) || (job_r.century[1:0] == 2'b00));
    if ((job_r.month == mcg_pkg::FEBRUARY) && leap) begin
      dm_nxt = 5'd29;
    end else begin
      dm_nxt = mcg_pkg::month_len(job_r.month);
    end
  end

  always_comb begin
    gap      = (cfg.cell_gap > mcg_pkg::MAX_GAP) ? mcg_pkg::MAX_GAP : cfg.cell_gap;
    step     = 3'(gap) + 3'd2;
    col_calc = 6'(step) * 6'(dw_r) + 6'(cfg.left_margin);
  end

  assign load      = (state_r == mcg_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign final_day = (cd_r == dm_r);
  assign q_pop     = (state_r == mcg_pkg::ST_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    dw_nxt        = dw_r;
    cd_nxt        = cd_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      mcg_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = mcg_pkg::ST_CALC;
        end
      end
      mcg_pkg::ST_CALC: begin
        state_nxt = mcg_pkg::ST_WDAY;
      end
      mcg_pkg::ST_WDAY: begin
        dw_nxt    = shifted[2:0];
        cd_nxt    = 5'd1;
        row_nxt   = '0;
        state_nxt = mcg_pkg::ST_EMIT;
      end
      mcg_pkg::ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          cd_nxt        = cd_r + 5'd1;
          if (dw_r == 3'(mcg_pkg::DAYS_WEEK - 4'd1)) begin
            dw_nxt  = '0;
            row_nxt = row_r + 3'd1;
          end else begin
            dw_nxt = dw_r + 3'd1;
          end
          if (final_day) begin
            state_nxt = mcg_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mcg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (state_r == mcg_pkg::ST_CALC) begin
      s_r <= s_nxt;
    end
    if (state_r == mcg_pkg::ST_WDAY) begin
      dm_r <= dm_nxt;
    end
    dw_r  <= dw_nxt;
    cd_r  <= cd_nxt;
    row_r <= row_nxt;
    if (load) begin
      day_r  <= cd_r;
      orow_r <= row_r;
      col_r  <= col_calc[mcg_pkg::COL_W-1:0];
      hl_r   <= (cd_r == job_r.day);
      last_r <= final_day;
      oc_r   <= job_r.century;
      oy_r   <= job_r.year;
      om_r   <= job_r.month;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.day_number        = day_r;
  assign out_ch.week_row          = orow_r;
  assign out_ch.char_column       = col_r;
  assign out_ch.highlight         = hl_r;
  assign out_ch.shown_century_out = oc_r;
  assign out_ch.shown_year_out    = oy_r;
  assign out_ch.shown_month_out   = om_r;
  assign out_ch.last_cell         = last_r;

  a_last_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (day_r >= 5'd28))
    else $error("month ended before day 28");

  a_cell_in_month: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcg_pkg::ST_EMIT) |-> ((cd_r <= dm_r) && (row_r <= 3'd5)))
    else $error("cell counter ran past the month");

  a_end_of_month: assert property (@(posedge clk) disable iff (!rst_n)
    (load && final_day) |=> ((state_r == mcg_pkg::ST_IDLE) && out_valid_r && last_r))
    else $error("final cell did not close the month");

  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (col_r <= 5'd27))
    else $error("cell column beyond grid");

endmodule

// File: sv/month_calendar_grid_navigator.sv
// month calendar grid navigator: a queued command yields one cell word per day of the month
// a taken command is queued unless it is unknown or today is already shown and marked; it then passes the idle, calc
// and weekday states; then one cell per cycle unless stalled. The cell generator takes the next month job only
// after the last cell of the one before; it sets the rate. A two-entry job queue lets the front end take commands
// while cells drain. Sync reset: 00/00/01 shown, no day marked, first_weekday 0, left_margin 3, cell_gap 2
// depends on mcg_pkg, mcg_in_if, mcg_out_if, mcg_front, mcg_queue, mcg_back
module month_calendar_grid_navigator (
  input  logic                            clk,
  input  logic                            rst_n,
  mcg_in_if.sink                          in_ch,
  mcg_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcg_pkg::CFG_W-1:0]       cfg_wdata
);

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  mcg_pkg::cfg_t cfg_r, cfg_nxt;

  // front end to queue
  logic          push, push_ready;
  mcg_pkg::job_t push_job;

  // queue to cell generator
  logic          pop, pop_valid;
  mcg_pkg::job_t pop_job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mcg_pkg::REG_FIRST_WEEKDAY: cfg_nxt.first_weekday = cfg_wdata;
        mcg_pkg::REG_LEFT_MARGIN:   cfg_nxt.left_margin   = cfg_wdata[1:0];
        mcg_pkg::REG_CELL_GAP:      cfg_nxt.cell_gap      = cfg_wdata[1:0];
        default:                    cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{first_weekday: 3'd0, left_margin: 2'd3, cell_gap: 2'd2};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // command decode and shown-month tracking
  mcg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (push_ready),
    .q_push  (push),
    .q_job   (push_job)
  );

  // month jobs waiting for the cell generator
  mcg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  // weekday and length of month, then one cell word per day
  mcg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (pop_valid),
    .q_job   (pop_job),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
